// ===== rtl/mnps_pkg.sv =====
`default_nettype none

package mnps_pkg;

    // Width of a MIDI data byte and of the channel filter register.
    localparam int NOTE_W = 7;
    localparam int CFG_W  = 5;

    // Message types, taken from the upper nibble of the status byte.
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;

    // Channel filter value that lets every channel through.
    localparam logic [CFG_W-1:0] CHAN_OMNI = 5'd0;

    // Note that sounds after reset (A4, 440 Hz).
    localparam logic [NOTE_W-1:0] RESET_NOTE = 7'd69;

    // Depth of the queues between the ports and the two halves of the block.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]        status_byte;
        logic [NOTE_W-1:0] note_byte;
        logic [NOTE_W-1:0] velocity_byte;
    } t_msg;

    typedef struct packed {
        logic              gate;
        logic [NOTE_W-1:0] current_note;
        logic [21:0]       frequency_q8;
        logic [NOTE_W-1:0] current_velocity;
        logic [4:0]        held_count;
    } t_result;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ON,
        OP_OFF
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETTLE,
        ST_NOTE,
        ST_FREQ
    } t_back_state;

    // 1760 Hz times 2^(r/12), in Q16, for each semitone r of the octave.
    function automatic logic [27:0] base_q16(input logic [3:0] semi);
        logic [27:0] val;
        case (semi)
            4'd0:    val = 28'd115343360;
            4'd1:    val = 28'd122202033;
            4'd2:    val = 28'd129468544;
            4'd3:    val = 28'd137167144;
            4'd4:    val = 28'd145323527;
            4'd5:    val = 28'd153964914;
            4'd6:    val = 28'd163120144;
            4'd7:    val = 28'd172819773;
            4'd8:    val = 28'd183096171;
            4'd9:    val = 28'd193983636;
            4'd10:   val = 28'd205518503;
            4'd11:   val = 28'd217739269;
            default: val = 28'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mnps_fifo.sv =====
`default_nettype none

module mnps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mnps_front.sv =====
`default_nettype none

module mnps_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mnps_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire mnps_pkg::t_msg              i_msg,
    output mnps_pkg::t_cmd                   o_cmd
);

    logic [mnps_pkg::CFG_W-1:0] r_filter;
    logic [mnps_pkg::CFG_W-1:0] chan;
    logic                       chan_ok;
    logic                       vel_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= mnps_pkg::CHAN_OMNI;
        end else if (i_cfg_we) begin
            r_filter <= i_cfg_wdata;
        end
    end

    // Channel numbers run from 1 to 16; a filter above 16 matches nothing.
    assign chan     = {1'b0, i_msg.status_byte[3:0]} + mnps_pkg::CFG_W'(1);
    assign chan_ok  = (r_filter == mnps_pkg::CHAN_OMNI) || (r_filter == chan);
    assign vel_zero = (i_msg.velocity_byte == '0);

    always_comb begin
        o_cmd.note = i_msg.note_byte;
        o_cmd.vel  = i_msg.velocity_byte;
        o_cmd.op   = mnps_pkg::OP_NOP;
        if (chan_ok) begin
            unique case (i_msg.status_byte[7:4])
                mnps_pkg::MSG_NOTE_ON:  o_cmd.op = vel_zero ? mnps_pkg::OP_OFF
                                                            : mnps_pkg::OP_ON;
                mnps_pkg::MSG_NOTE_OFF: o_cmd.op = mnps_pkg::OP_OFF;
                default:                o_cmd.op = mnps_pkg::OP_NOP;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mnps_back.sv =====
`default_nettype none

module mnps_back #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire mnps_pkg::t_cmd    i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output mnps_pkg::t_result      o_res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NW = mnps_pkg::NOTE_W;

    mnps_pkg::t_back_state r_state;
    mnps_pkg::t_back_state n_state;

    // Entry 0 is the newest note; older notes sit at higher entries.
    logic [NW-1:0]          r_note [STACK_DEPTH];
    logic [NW-1:0]          r_vel  [STACK_DEPTH];
    logic [NW-1:0]          n_note [STACK_DEPTH];
    logic [NW-1:0]          n_vel  [STACK_DEPTH];
    logic [NW-1:0]          up_note [STACK_DEPTH];
    logic [NW-1:0]          up_vel  [STACK_DEPTH];
    logic [NW-1:0]          dn_note [STACK_DEPTH];
    logic [NW-1:0]          dn_vel  [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] n_match;
    logic [STACK_DEPTH-1:0] r_match;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          count_m1;
    logic [IW-1:0]          r_idx;
    logic                   r_gate;
    logic [NW-1:0]          r_snd_note;
    logic [NW-1:0]          r_snd_vel;
    logic [3:0]             r_oct;
    logic [3:0]             r_semi;

    logic       stk_push;
    logic       stk_remove;
    logic       settle;
    logic [7:0] note_ofs;
    logic [15:0] prod;
    logic [3:0] oct;
    logic [7:0] oct_x12;
    logic [7:0] semi;
    logic [37:0] scaled;
    logic [37:0] rounded;
    logic [CW+4:0] count_ext;

    // Neighbour taps for the shift on push and the compaction on removal.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_taps
        if (g < STACK_DEPTH - 1) begin : g_up
            assign up_note[g] = r_note[g+1];
            assign up_vel[g]  = r_vel[g+1];
        end else begin : g_top
            assign up_note[g] = r_note[g];
            assign up_vel[g]  = r_vel[g];
        end
        if (g > 0) begin : g_dn
            assign dn_note[g] = r_note[g-1];
            assign dn_vel[g]  = r_vel[g-1];
        end else begin : g_new
            assign dn_note[g] = i_cmd.note;
            assign dn_vel[g]  = i_cmd.vel;
        end
        assign n_match[g] = (r_note[g] == i_cmd.note) && (CW'(g) < r_count);
    end

    always_comb begin
        for (int j = 0; j < STACK_DEPTH; j++) begin
            n_note[j] = r_note[j];
            n_vel[j]  = r_vel[j];
            if (stk_push) begin
                n_note[j] = dn_note[j];
                n_vel[j]  = dn_vel[j];
            end else if (stk_remove && (IW'(j) >= r_idx)) begin
                n_note[j] = up_note[j];
                n_vel[j]  = up_vel[j];
            end
        end
    end

    assign count_m1 = r_count - CW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mnps_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == mnps_pkg::OP_OFF) begin
                        n_state = (r_count == '0) ? mnps_pkg::ST_SETTLE
                                                  : mnps_pkg::ST_SCAN;
                    end else begin
                        n_state = mnps_pkg::ST_NOTE;
                    end
                end
            end
            mnps_pkg::ST_SCAN: begin
                if (r_match[r_idx] || (r_idx == '0)) begin
                    n_state = mnps_pkg::ST_SETTLE;
                end
            end
            mnps_pkg::ST_SETTLE: n_state = mnps_pkg::ST_NOTE;
            mnps_pkg::ST_NOTE:   n_state = mnps_pkg::ST_FREQ;
            mnps_pkg::ST_FREQ: begin
                if (!i_res_full) begin
                    n_state = mnps_pkg::ST_IDLE;
                end
            end
            default: n_state = mnps_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_cmd_pop  = 1'b0;
        stk_push   = 1'b0;
        stk_remove = 1'b0;
        settle     = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            mnps_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                stk_push  = i_cmd_valid && (i_cmd.op == mnps_pkg::OP_ON);
            end
            mnps_pkg::ST_SCAN:   stk_remove = r_match[r_idx];
            mnps_pkg::ST_SETTLE: settle = 1'b1;
            mnps_pkg::ST_FREQ:   o_res_push = !i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mnps_pkg::ST_IDLE;
            r_count    <= '0;
            r_gate     <= 1'b0;
            r_snd_note <= mnps_pkg::RESET_NOTE;
            r_snd_vel  <= '0;
        end else begin
            r_state <= n_state;
            if (stk_push) begin
                if (r_count != CW'(STACK_DEPTH)) begin
                    r_count <= r_count + CW'(1);
                end
                r_gate     <= 1'b1;
                r_snd_note <= i_cmd.note;
                r_snd_vel  <= i_cmd.vel;
            end else if (stk_remove) begin
                r_count <= count_m1;
            end else if (settle) begin
                if (r_count == '0) begin
                    r_gate <= 1'b0;
                end else begin
                    r_snd_note <= r_note[0];
                    r_snd_vel  <= r_vel[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < STACK_DEPTH; j++) begin
            r_note[j] <= n_note[j];
            r_vel[j]  <= n_vel[j];
        end
        if (o_cmd_pop) begin
            r_match <= n_match;
            r_idx   <= count_m1[IW-1:0];
        end else if ((r_state == mnps_pkg::ST_SCAN) && !stk_remove) begin
            r_idx <= r_idx - IW'(1);
        end
        r_oct  <= oct;
        r_semi <= semi[3:0];
    end

    // Octave and semitone of note + 3, dividing by 12 through the
    // reciprocal 171 / 2048, which is exact for every 7-bit note.
    assign note_ofs = {1'b0, r_snd_note} + 8'd3;
    assign prod     = 16'(note_ofs) * 16'd171;
    assign oct      = prod[14:11];
    assign oct_x12  = 8'({oct, 3'b000}) + 8'({oct, 2'b00});
    assign semi     = note_ofs - oct_x12;

    assign scaled  = {10'd0, mnps_pkg::base_q16(r_semi)} << r_oct;
    assign rounded = scaled + 38'd32768;

    assign count_ext = {5'd0, r_count};

    always_comb begin
        o_res.gate             = r_gate;
        o_res.current_note     = r_snd_note;
        o_res.frequency_q8     = rounded[37:16];
        o_res.current_velocity = r_snd_vel;
        o_res.held_count       = count_ext[4:0];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("held-note count beyond stack depth");

    a_gate_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mnps_pkg::ST_IDLE) |-> (r_gate == (r_count != '0)))
        else $error("gate disagrees with the held-note count between words");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mnps_pkg::ST_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("stack scan outside the held entries");

    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state != mnps_pkg::ST_IDLE))
        else $error("command taken without leaving idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/mono_note_priority_stack.sv =====
// Monophonic MIDI-to-CV converter with last-note priority.
// Input channel: a word is a three-byte MIDI channel message on i_msg. It is
// taken at a rising edge with push high and full low. The channel filter is
// written through i_cfg_we / i_cfg_wdata: 0 passes every channel, 1 to 16 one
// channel only. It should only be written while no word is in flight.
// Result channel: every message, dropped or not, yields exactly one word on
// o_result giving gate, sounding note and velocity, its frequency in Q14.8
// and the number of held notes. The oldest word is shown while empty is low
// and is taken at an edge with pop high.
// In the back part every word passes the note state and then the frequency
// state, which holds while the output queue is full. A release first passes
// the settle state, preceded on a non-empty stack by the one-entry-per-cycle
// scan of the held-note stack, which sets how long a release takes. One word
// is in work at a time: the back part takes no new command until the
// current result is queued.
// Reset empties the stack, drops the gate, sets the sounding note to 69
// (440 Hz) with velocity 0 and sets the filter to all channels.
// When the receiver stalls, two results wait in the output queue, then the
// back part holds, the two-word command queue fills and full rises.
`default_nettype none

module mono_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    input  wire mnps_pkg::t_msg              i_msg,
    output logic                             full,
    output logic                             empty,
    input  wire logic                        pop,
    output mnps_pkg::t_result                o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [mnps_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int CMD_W = $bits(mnps_pkg::t_cmd);
    localparam int RES_W = $bits(mnps_pkg::t_result);

    mnps_pkg::t_cmd    front_cmd;
    mnps_pkg::t_cmd    back_cmd;
    logic [CMD_W-1:0]  cmd_q_data;
    logic              cmd_q_empty;
    logic              cmd_pop;
    mnps_pkg::t_result back_res;
    logic              res_push;
    logic              res_full;
    logic [RES_W-1:0]  res_q_data;

    // The front part checks the channel and sorts the message into a
    // note-on, a release or a message that changes nothing.
    mnps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_msg       (i_msg),
        .o_cmd       (front_cmd)
    );

    mnps_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (mnps_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_q_data),
        .o_empty (cmd_q_empty)
    );

    assign back_cmd = mnps_pkg::t_cmd'(cmd_q_data);

    // The back part owns the held-note stack and works out each result.
    mnps_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_q_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Output queue, so that a stalled receiver does not hold the back part
    // until two results are waiting.
    mnps_fifo #(
        .WIDTH (RES_W),
        .DEPTH (mnps_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_q_data),
        .o_empty (empty)
    );

    assign o_result = mnps_pkg::t_result'(res_q_data);

endmodule

`default_nettype wire
